FILE: rtl/pbp_pkg.sv
// ----------------------------------------------------------------------------
// pbp_pkg: shared types and constants of the PLL and bus prescaler planner
// Field widths, request/result word layouts and the VCO frequency plan limits.
// ----------------------------------------------------------------------------
`default_nettype none

package pbp_pkg;

  localparam int unsigned OscW  = 26;
  localparam int unsigned FreqW = 28;
  localparam int unsigned MW    = 6;
  localparam int unsigned NW    = 9;
  localparam int unsigned PW    = 2;
  localparam int unsigned QW    = 4;
  localparam int unsigned AhbW  = 4;
  localparam int unsigned ApbW  = 3;

  localparam longint unsigned VcoMinHz = 64'd192_000_000;
  localparam longint unsigned VcoMaxHz = 64'd432_000_000;
  localparam longint unsigned UsbHz    = 64'd48_000_000;
  localparam longint unsigned MhzHz    = 64'd1_000_000;

  // VCO must be k * 48 MHz with k in [KLo, KHi]
  localparam int unsigned KLo = int'(VcoMinHz / UsbHz);
  localparam int unsigned KHi = int'(VcoMaxHz / UsbHz);
  // VCO in MHz per step of k
  localparam int unsigned NStep = int'(UsbHz / MhzHz);

  // Number of P candidates (2, 4, 6, 8)
  localparam int unsigned NumP = 4;

  typedef struct packed {
    logic             pll_enable;
    logic             source_is_hse;
    logic [OscW-1:0]  internal_osc_hz;
    logic [OscW-1:0]  external_osc_hz;
    logic [FreqW-1:0] pll_out_hz;
    logic [FreqW-1:0] core_hz;
    logic [FreqW-1:0] bus1_hz;
    logic [FreqW-1:0] bus2_hz;
  } req_t;

  typedef struct packed {
    logic            plan_failed;
    logic            src_select;
    logic [MW-1:0]   div_m;
    logic [NW-1:0]   mul_n;
    logic [PW-1:0]   div_p_code;
    logic [QW-1:0]   div_q;
    logic [AhbW-1:0] core_prescale;
    logic [ApbW-1:0] bus1_prescale;
    logic [ApbW-1:0] bus2_prescale;
  } res_t;

  // VCO search outcome
  typedef struct packed {
    logic          found;
    logic [PW-1:0] p_code;
    logic [NW-1:0] mul_n;
    logic [QW-1:0] div_q;
  } vco_plan_t;

endpackage

`default_nettype wire

FILE: rtl/pbp_req_if.sv
// ----------------------------------------------------------------------------
// pbp_req_if: request channel
// Valid/ready handshake carrying one planning request word.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbp_req_if import pbp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             pll_enable;
  logic             source_is_hse;
  logic [OscW-1:0]  internal_osc_hz;
  logic [OscW-1:0]  external_osc_hz;
  logic [FreqW-1:0] pll_out_hz;
  logic [FreqW-1:0] core_hz;
  logic [FreqW-1:0] bus1_hz;
  logic [FreqW-1:0] bus2_hz;

  modport source (
    output valid, pll_enable, source_is_hse, internal_osc_hz, external_osc_hz,
           pll_out_hz, core_hz, bus1_hz, bus2_hz,
    input  ready
  );

  modport sink (
    input  valid, pll_enable, source_is_hse, internal_osc_hz, external_osc_hz,
           pll_out_hz, core_hz, bus1_hz, bus2_hz,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/pbp_res_if.sv
// ----------------------------------------------------------------------------
// pbp_res_if: result channel
// Valid/ready handshake carrying one divider and prescaler plan word.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbp_res_if import pbp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            plan_failed;
  logic            src_select;
  logic [MW-1:0]   div_m;
  logic [NW-1:0]   mul_n;
  logic [PW-1:0]   div_p_code;
  logic [QW-1:0]   div_q;
  logic [AhbW-1:0] core_prescale;
  logic [ApbW-1:0] bus1_prescale;
  logic [ApbW-1:0] bus2_prescale;

  modport source (
    output valid, plan_failed, src_select, div_m, mul_n, div_p_code, div_q,
           core_prescale, bus1_prescale, bus2_prescale,
    input  ready
  );

  modport sink (
    input  valid, plan_failed, src_select, div_m, mul_n, div_p_code, div_q,
           core_prescale, bus1_prescale, bus2_prescale,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/pbp_mdiv.sv
// ----------------------------------------------------------------------------
// pbp_mdiv: PLL input divider
// Source frequency divided by 1 MHz through a reciprocal multiply,
// saturated to the width of the M field.
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_mdiv import pbp_pkg::*; (
  input  logic [OscW-1:0] src_hz_i,
  output logic [MW-1:0]   div_m_o
);

  // 2^46 / 1e6 rounded up; exact for every OscW-bit input
  localparam int unsigned MShift = 46;
  localparam int unsigned RecipW = 27;
  localparam int unsigned ProdW  = OscW + RecipW;
  localparam int unsigned QuotW  = ProdW - MShift;
  localparam longint unsigned MRecip = ((64'd1 << MShift) / MhzHz) + 64'd1;
  localparam logic [QuotW-1:0] MSat = QuotW'((1 << MW) - 1);

  logic [ProdW-1:0] prod;
  logic [QuotW-1:0] quot;

  assign prod = ProdW'(src_hz_i) * ProdW'(MRecip);
  assign quot = prod[ProdW-1:MShift];

  assign div_m_o = (quot > MSat) ? MW'(MSat) : quot[MW-1:0];

endmodule

`default_nettype wire

FILE: rtl/pbp_vco_plan.sv
// ----------------------------------------------------------------------------
// pbp_vco_plan: VCO search
// Checks P = 2, 4, 6, 8 in parallel against every 48 MHz multiple inside the
// VCO range and takes the first P that lands on one.
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_vco_plan import pbp_pkg::*; (
  input  logic [FreqW-1:0] pll_out_hz_i,
  output vco_plan_t        plan_o
);

  localparam int unsigned VcoW = FreqW + 3;

  logic [VcoW-1:0] vco   [NumP];
  logic [NumP-1:0] hit;
  logic [QW-1:0]   k_sel [NumP];

  always_comb begin
    for (int i = 0; i < NumP; i++) begin
      // VCO = pll_out * 2 * (i + 1)
      vco[i]   = VcoW'(pll_out_hz_i) * VcoW'(2 * (i + 1));
      hit[i]   = 1'b0;
      k_sel[i] = '0;
      for (int k = KLo; k <= KHi; k++) begin
        if (vco[i] == VcoW'(longint'(k) * UsbHz)) begin
          hit[i]   = 1'b1;
          k_sel[i] = QW'(k);
        end
      end
    end
  end

  // Priority pick: lowest P wins
  always_comb begin
    plan_o = '0;
    for (int i = NumP - 1; i >= 0; i--) begin
      if (hit[i]) begin
        plan_o.found  = 1'b1;
        plan_o.p_code = PW'(i);
        plan_o.div_q  = k_sel[i];
        plan_o.mul_n  = NW'(k_sel[i]) * NW'(NStep);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pbp_prescale.sv
// ----------------------------------------------------------------------------
// pbp_prescale: bus prescaler ladders
// AHB code from the PLL output against the core clock, APB codes from the
// core clock against each bus clock.
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_prescale import pbp_pkg::*; (
  input  logic [FreqW-1:0] pll_out_hz_i,
  input  logic [FreqW-1:0] core_hz_i,
  input  logic [FreqW-1:0] bus1_hz_i,
  input  logic [FreqW-1:0] bus2_hz_i,
  output logic [AhbW-1:0]  core_prescale_o,
  output logic [ApbW-1:0]  bus1_prescale_o,
  output logic [ApbW-1:0]  bus2_prescale_o
);

  localparam int unsigned CmpW = FreqW + 3;

  localparam logic [AhbW-1:0] AhbNone = 4'h0;
  localparam logic [AhbW-1:0] AhbDiv2 = 4'h8;
  localparam logic [AhbW-1:0] AhbDiv4 = 4'h9;
  localparam logic [AhbW-1:0] AhbDiv8 = 4'ha;

  localparam logic [ApbW-1:0] ApbNone  = 3'h0;
  localparam logic [ApbW-1:0] ApbDiv2  = 3'h4;
  localparam logic [ApbW-1:0] ApbDiv4  = 3'h5;
  localparam logic [ApbW-1:0] ApbDiv8  = 3'h6;
  localparam logic [ApbW-1:0] ApbDiv16 = 3'h7;

  function automatic logic [ApbW-1:0] apb_code(input logic [FreqW-1:0] core,
                                              input logic [FreqW-1:0] bus);
    logic [CmpW-1:0] c;
    logic [CmpW-1:0] b;
    c = CmpW'(core);
    b = CmpW'(bus);
    if (c > (b << 3)) return ApbDiv16;
    if (c > (b << 2)) return ApbDiv8;
    if (c > (b << 1)) return ApbDiv4;
    if (c > b)        return ApbDiv2;
    return ApbNone;
  endfunction

  logic [CmpW-1:0] pll_w;
  logic [CmpW-1:0] core_w;

  assign pll_w  = CmpW'(pll_out_hz_i);
  assign core_w = CmpW'(core_hz_i);

  always_comb begin
    if (pll_w > (core_w << 2)) begin
      core_prescale_o = AhbDiv8;
    end else if (pll_w > (core_w << 1)) begin
      core_prescale_o = AhbDiv4;
    end else if (pll_w > core_w) begin
      core_prescale_o = AhbDiv2;
    end else begin
      core_prescale_o = AhbNone;
    end
  end

  assign bus1_prescale_o = apb_code(core_hz_i, bus1_hz_i);
  assign bus2_prescale_o = apb_code(core_hz_i, bus2_hz_i);

endmodule

`default_nettype wire

FILE: rtl/pll_and_bus_prescaler_planner.sv
// ----------------------------------------------------------------------------
// pll_and_bus_prescaler_planner: PLL divider and bus prescaler planner
// Registers a request word, plans M/N/P/Q and the bus prescaler codes in one
// combinational pass, and registers the result word.
//
//   channel  | dir | word
//   ---------+-----+-----------------------------------------------
//   req_i    | in  | enables, oscillator and wanted clock frequencies
//   res_o    | out | fail flag, PLL dividers, AHB/APB prescaler codes
//
// One word per cycle unless res_o stalls; stages: s1_q input, res_q result.
// The rate is set by the single pass from the input register to the result
// register (one 26x27 reciprocal multiply, parallel VCO compares).
// Reset clears only the stage valid flags.
// A stalled result holds the result stage and a full input stage; a bubble in either stage is filled.
// ----------------------------------------------------------------------------
`default_nettype none

module pll_and_bus_prescaler_planner import pbp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pbp_req_if.sink   req_i,
  pbp_res_if.source res_o
);

  logic      s1_vld_q;
  req_t      s1_q;
  req_t      s1_d;
  logic      s2_vld_q;
  res_t      res_q;
  res_t      res_d;
  logic      adv2;
  logic      adv1;

  logic [OscW-1:0] src_hz;
  logic [MW-1:0]   div_m;
  vco_plan_t       plan;
  logic [AhbW-1:0] core_code;
  logic [ApbW-1:0] bus1_code;
  logic [ApbW-1:0] bus2_code;

  assign adv2        = !s2_vld_q || res_o.ready;
  assign adv1        = !s1_vld_q || adv2;
  assign req_i.ready = adv1;

  always_comb begin
    s1_d.pll_enable      = req_i.pll_enable;
    s1_d.source_is_hse   = req_i.source_is_hse;
    s1_d.internal_osc_hz = req_i.internal_osc_hz;
    s1_d.external_osc_hz = req_i.external_osc_hz;
    s1_d.pll_out_hz      = req_i.pll_out_hz;
    s1_d.core_hz         = req_i.core_hz;
    s1_d.bus1_hz         = req_i.bus1_hz;
    s1_d.bus2_hz         = req_i.bus2_hz;
  end

  assign src_hz = s1_q.source_is_hse ? s1_q.external_osc_hz : s1_q.internal_osc_hz;

  pbp_mdiv u_mdiv (
    .src_hz_i (src_hz),
    .div_m_o  (div_m)
  );

  pbp_vco_plan u_vco_plan (
    .pll_out_hz_i (s1_q.pll_out_hz),
    .plan_o       (plan)
  );

  pbp_prescale u_prescale (
    .pll_out_hz_i    (s1_q.pll_out_hz),
    .core_hz_i       (s1_q.core_hz),
    .bus1_hz_i       (s1_q.bus1_hz),
    .bus2_hz_i       (s1_q.bus2_hz),
    .core_prescale_o (core_code),
    .bus1_prescale_o (bus1_code),
    .bus2_prescale_o (bus2_code)
  );

  // Failed plan: flag only, every other field zero
  always_comb begin
    res_d = '0;
    if (s1_q.pll_enable && !plan.found) begin
      res_d.plan_failed = 1'b1;
    end else begin
      if (s1_q.pll_enable) begin
        res_d.src_select = s1_q.source_is_hse;
        res_d.div_m      = div_m;
        res_d.mul_n      = plan.mul_n;
        res_d.div_p_code = plan.p_code;
        res_d.div_q      = plan.div_q;
      end
      res_d.core_prescale = core_code;
      res_d.bus1_prescale = bus1_code;
      res_d.bus2_prescale = bus2_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (adv1) begin
        s1_vld_q <= req_i.valid;
      end
      if (adv2) begin
        s2_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && req_i.valid) begin
      s1_q <= s1_d;
    end
    if (adv2 && s1_vld_q) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid         = s2_vld_q;
  assign res_o.plan_failed   = res_q.plan_failed;
  assign res_o.src_select    = res_q.src_select;
  assign res_o.div_m         = res_q.div_m;
  assign res_o.mul_n         = res_q.mul_n;
  assign res_o.div_p_code    = res_q.div_p_code;
  assign res_o.div_q         = res_q.div_q;
  assign res_o.core_prescale = res_q.core_prescale;
  assign res_o.bus1_prescale = res_q.bus1_prescale;
  assign res_o.bus2_prescale = res_q.bus2_prescale;

endmodule

`default_nettype wire

FILE: test/pbp_plan_checker.sv
// ----------------------------------------------------------------------------
// pbp_plan_checker: plan predictor and scoreboard for the prescaler planner
// Watches the request and result channels, predicts the PLL divider fields
// and the bus prescaler codes of every accepted request, and compares each
// accepted result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module pbp_plan_checker import pbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pbp_req_if          req_i,
  pbp_res_if          res_i,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o
);

  localparam logic [AhbW-1:0] AhbDiv1  = 4'h0;
  localparam logic [AhbW-1:0] AhbDiv2  = 4'h8;
  localparam logic [AhbW-1:0] AhbDiv4  = 4'h9;
  localparam logic [AhbW-1:0] AhbDiv8  = 4'hA;
  localparam logic [ApbW-1:0] ApbDiv1  = 3'h0;
  localparam logic [ApbW-1:0] ApbDiv2  = 3'h4;
  localparam logic [ApbW-1:0] ApbDiv4  = 3'h5;
  localparam logic [ApbW-1:0] ApbDiv8  = 3'h6;
  localparam logic [ApbW-1:0] ApbDiv16 = 3'h7;

  localparam longint unsigned MaxDivM     = 63;
  localparam int unsigned     ReportLimit = 10;

  res_t expected_plans[$];

  function automatic logic [ApbW-1:0] apb_prescale(longint unsigned core,
                                                   longint unsigned bus);
    if (core > bus * 8) return ApbDiv16;
    if (core > bus * 4) return ApbDiv8;
    if (core > bus * 2) return ApbDiv4;
    if (core > bus) return ApbDiv2;
    return ApbDiv1;
  endfunction

  function automatic res_t plan_clocks(req_t r);
    res_t            plan;
    longint unsigned pll;
    longint unsigned core;
    longint unsigned src;
    longint unsigned vco;
    longint unsigned m;
    longint unsigned p;
    bit              found;
    plan  = '0;
    pll   = r.pll_out_hz;
    core  = r.core_hz;
    found = 1'b0;
    p     = 0;
    if (r.pll_enable) begin
      src = r.source_is_hse ? r.external_osc_hz : r.internal_osc_hz;
      // take the smallest P that lands the VCO on a 48 MHz multiple in range
      for (longint unsigned cand = 2; cand <= 8; cand += 2) begin
        vco = pll * cand;
        if (!found && vco >= VcoMinHz && vco <= VcoMaxHz && (vco % UsbHz) == 0) begin
          found = 1'b1;
          p     = cand;
        end
      end
      if (!found) begin
        plan.plan_failed = 1'b1;
        return plan;
      end
      vco = pll * p;
      m   = src / MhzHz;
      if (m > MaxDivM) m = MaxDivM;
      plan.src_select = r.source_is_hse;
      plan.div_m      = MW'(m);
      plan.mul_n      = NW'(vco / MhzHz);
      plan.div_p_code = PW'(p / 2 - 1);
      plan.div_q      = QW'(vco / UsbHz);
    end
    if (pll > core * 4)      plan.core_prescale = AhbDiv8;
    else if (pll > core * 2) plan.core_prescale = AhbDiv4;
    else if (pll > core)     plan.core_prescale = AhbDiv2;
    else                     plan.core_prescale = AhbDiv1;
    plan.bus1_prescale = apb_prescale(core, r.bus1_hz);
    plan.bus2_prescale = apb_prescale(core, r.bus2_hz);
    return plan;
  endfunction

  function automatic string plan_text(res_t w);
    return $sformatf("fail=%0d src=%0d m=%0d n=%0d p=%0d q=%0d ahb=%h apb1=%h apb2=%h",
                     w.plan_failed, w.src_select, w.div_m, w.mul_n, w.div_p_code,
                     w.div_q, w.core_prescale, w.bus1_prescale, w.bus2_prescale);
  endfunction

  initial begin
    mismatches_o  = 0;
    outstanding_o = 0;
  end

  always @(posedge clk_i) begin
    req_t got_req;
    res_t got;
    res_t want;
    if (rst_ni) begin
      if (req_i.valid && req_i.ready) begin
        got_req = '{pll_enable:      req_i.pll_enable,
                    source_is_hse:   req_i.source_is_hse,
                    internal_osc_hz: req_i.internal_osc_hz,
                    external_osc_hz: req_i.external_osc_hz,
                    pll_out_hz:      req_i.pll_out_hz,
                    core_hz:         req_i.core_hz,
                    bus1_hz:         req_i.bus1_hz,
                    bus2_hz:         req_i.bus2_hz};
        expected_plans.push_back(plan_clocks(got_req));
      end
      if (res_i.valid && res_i.ready) begin
        got = '{plan_failed:   res_i.plan_failed,
                src_select:    res_i.src_select,
                div_m:         res_i.div_m,
                mul_n:         res_i.mul_n,
                div_p_code:    res_i.div_p_code,
                div_q:         res_i.div_q,
                core_prescale: res_i.core_prescale,
                bus1_prescale: res_i.bus1_prescale,
                bus2_prescale: res_i.bus2_prescale};
        if (expected_plans.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= ReportLimit)
            $display("%0t: plan word with no request pending: %s", $realtime,
                     plan_text(got));
        end else begin
          want = expected_plans.pop_front();
          if (got.plan_failed   !== want.plan_failed   ||
              got.src_select    !== want.src_select    ||
              got.div_m         !== want.div_m         ||
              got.mul_n         !== want.mul_n         ||
              got.div_p_code    !== want.div_p_code    ||
              got.div_q         !== want.div_q         ||
              got.core_prescale !== want.core_prescale ||
              got.bus1_prescale !== want.bus1_prescale ||
              got.bus2_prescale !== want.bus2_prescale) begin
            mismatches_o++;
            if (mismatches_o <= ReportLimit) begin
              $display("%0t: plan mismatch", $realtime);
              $display("  expected %s", plan_text(want));
              $display("  actual   %s", plan_text(got));
            end
          end
        end
      end
      outstanding_o = expected_plans.size();
    end
  end

endmodule

FILE: test/pll_and_bus_prescaler_planner_tb.sv
// ----------------------------------------------------------------------------
// pll_and_bus_prescaler_planner_tb: testbench of the prescaler planner
// Sends directed corner requests and then random ones, mostly with PLL output
// frequencies that fit a VCO plan, in bursts with gaps while the result side
// stalls; a checker beside the block predicts and compares every plan word.
// ----------------------------------------------------------------------------

module pll_and_bus_prescaler_planner_tb;
  import pbp_pkg::*;

  localparam int unsigned NumRandom   = 380;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned DrainCycles = 10;

  typedef enum int unsigned {
    FlowFree,
    FlowCoinFlip,
    FlowChoked,
    FlowPeriodic
  } stall_mode_e;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;

  pbp_req_if req_if ();
  pbp_res_if res_if ();

  pll_and_bus_prescaler_planner dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  pbp_plan_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_i         (req_if),
    .res_i         (res_if),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // end the run when neither channel moves a word for too long
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side stalls on a pattern that is picked anew at random after each span
  initial begin
    stall_mode_e mode;
    int unsigned span;
    res_if.ready = 1'b0;
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      span = $urandom_range(16, 96);
      for (int unsigned tick = 0; tick < span; tick++) begin
        @(negedge clk);
        case (mode)
          FlowFree:     res_if.ready <= 1'b1;
          FlowCoinFlip: res_if.ready <= 1'($urandom_range(0, 1));
          FlowChoked:   res_if.ready <= ($urandom_range(0, 3) == 0);
          default:      res_if.ready <= (tick % 5 != 4);
        endcase
      end
    end
  end

  function automatic req_t make_req(bit en, bit hse, longint unsigned hsi_hz,
                                    longint unsigned hse_hz, longint unsigned pll_hz,
                                    longint unsigned core_hz, longint unsigned b1_hz,
                                    longint unsigned b2_hz);
    req_t r;
    r.pll_enable      = en;
    r.source_is_hse   = hse;
    r.internal_osc_hz = OscW'(hsi_hz);
    r.external_osc_hz = OscW'(hse_hz);
    r.pll_out_hz      = FreqW'(pll_hz);
    r.core_hz         = FreqW'(core_hz);
    r.bus1_hz         = FreqW'(b1_hz);
    r.bus2_hz         = FreqW'(b2_hz);
    return r;
  endfunction

  function automatic longint unsigned random_osc();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return $urandom_range(0, 50_000_000);
    if (pick < 9) return longint'($urandom_range(0, 50)) * MhzHz;
    return $urandom & 32'h03FF_FFFF;
  endfunction

  // mostly near base >> shift so the ladder thresholds get hit on both sides
  function automatic longint unsigned near_ratio(longint unsigned base,
                                                 int unsigned max_shift);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return (base >> $urandom_range(0, max_shift)) + $urandom_range(0, 2) - 1;
    if (pick < 90) return $urandom_range(1, 216_000_000);
    return $urandom & 32'h0FFF_FFFF;
  endfunction

  function automatic req_t random_req();
    longint unsigned fit;
    longint unsigned pll;
    longint unsigned core;
    int unsigned     pick;
    fit  = UsbHz / (2 * $urandom_range(1, 4)) * $urandom_range(KLo, KHi);
    pick = $urandom_range(0, 99);
    if (pick < 60)      pll = fit;
    else if (pick < 75) pll = fit + $urandom_range(0, 2000) - 1000;
    else if (pick < 90) pll = $urandom_range(1, 216_000_000);
    else                pll = $urandom & 32'h0FFF_FFFF;
    core = near_ratio(pll, 3);
    return make_req($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)), random_osc(),
                    random_osc(), pll, core, near_ratio(core, 4), near_ratio(core, 4));
  endfunction

  task automatic send_plan_req(input req_t r);
    int unsigned gap;
    req_if.valid           <= 1'b1;
    req_if.pll_enable      <= r.pll_enable;
    req_if.source_is_hse   <= r.source_is_hse;
    req_if.internal_osc_hz <= r.internal_osc_hz;
    req_if.external_osc_hz <= r.external_osc_hz;
    req_if.pll_out_hz      <= r.pll_out_hz;
    req_if.core_hz         <= r.core_hz;
    req_if.bus1_hz         <= r.bus1_hz;
    req_if.bus2_hz         <= r.bus2_hz;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  initial begin
    req_if.valid           = 1'b0;
    req_if.pll_enable      = 1'b0;
    req_if.source_is_hse   = 1'b0;
    req_if.internal_osc_hz = '0;
    req_if.external_osc_hz = '0;
    req_if.pll_out_hz      = '0;
    req_if.core_hz         = '0;
    req_if.bus1_hz         = '0;
    req_if.bus2_hz         = '0;
    wait (rst_n);
    @(negedge clk);

    // PLL off, all zero, and PLL off with live frequencies
    send_plan_req(make_req(0, 0, 0, 0, 0, 0, 0, 0));
    send_plan_req(make_req(0, 1, 50_000_000, 50_000_000, 200_000_000, 20_000_000,
                           1_000_000, 2_000_000));
    // zero PLL output never fits
    send_plan_req(make_req(1, 0, 16_000_000, 25_000_000, 0, 1, 1, 1));
    // VCO at the low and high ends, each P in turn
    send_plan_req(make_req(1, 0, 16_000_000, 25_000_000, 96_000_000, 96_000_000,
                           48_000_000, 96_000_000));
    send_plan_req(make_req(1, 1, 16_000_000, 25_000_000, 216_000_000, 216_000_000,
                           54_000_000, 108_000_000));
    send_plan_req(make_req(1, 0, 16_000_000, 8_000_000, 48_000_000, 48_000_000,
                           12_000_000, 24_000_000));
    send_plan_req(make_req(1, 1, 16_000_000, 8_000_000, 32_000_000, 16_000_000,
                           4_000_000, 1_000_000));
    send_plan_req(make_req(1, 0, 16_000_000, 8_000_000, 24_000_000, 24_000_000,
                           3_000_000, 24_000_000));
    send_plan_req(make_req(1, 1, 16_000_000, 8_000_000, 54_000_000, 27_000_000,
                           27_000_000, 13_500_000));
    // no P fits
    send_plan_req(make_req(1, 0, 16_000_000, 8_000_000, 100_000_000, 100_000_000,
                           50_000_000, 25_000_000));
    // M saturates, M rounds to zero, zero source
    send_plan_req(make_req(1, 0, 26'h3FF_FFFF, 0, 168_000_000, 168_000_000,
                           42_000_000, 84_000_000));
    send_plan_req(make_req(1, 1, 0, 26'h3FF_FFFF, 168_000_000, 168_000_000,
                           42_000_000, 84_000_000));
    send_plan_req(make_req(1, 0, 999_999, 16_000_000, 168_000_000, 84_000_000,
                           21_000_000, 42_000_000));
    send_plan_req(make_req(1, 1, 16_000_000, 0, 168_000_000, 84_000_000,
                           21_000_000, 42_000_000));
    // AHB ladder at and around its thresholds
    send_plan_req(make_req(1, 0, 8_000_000, 8_000_000, 216_000_000, 50_000_000,
                           26_000_000, 27_000_000));
    send_plan_req(make_req(1, 1, 8_000_000, 8_000_000, 216_000_000, 54_000_000,
                           54_000_000, 108_000_000));
    send_plan_req(make_req(1, 0, 8_000_000, 8_000_000, 216_000_000, 108_000_000,
                           216_000_000, 107_999_999));
    // APB ladders at and around their thresholds
    send_plan_req(make_req(1, 0, 8_000_000, 8_000_000, 216_000_000, 216_000_000,
                           26_000_000, 27_000_000));
    send_plan_req(make_req(1, 1, 8_000_000, 8_000_000, 216_000_000, 216_000_000,
                           54_000_000, 108_000_000));
    send_plan_req(make_req(1, 0, 8_000_000, 8_000_000, 216_000_000, 216_000_000,
                           216_000_000, 215_999_999));
    // full-width fields and zero buses
    send_plan_req(make_req(1, 1, 26'h3FF_FFFF, 26'h3FF_FFFF, 28'hFFF_FFFF,
                           28'hFFF_FFFF, 28'hFFF_FFFF, 28'hFFF_FFFF));
    send_plan_req(make_req(1, 0, 50_000_000, 50_000_000, 216_000_000, 28'hFFF_FFFF,
                           0, 1));
    send_plan_req(make_req(0, 0, 0, 0, 28'hFFF_FFFF, 0, 28'hFFF_FFFF, 0));

    repeat (NumRandom) send_plan_req(random_req());
    req_if.valid <= 1'b0;

    wait (outstanding == 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
